// ----- design/trimmed_mean_three_channel_core_defines.svh -----
// Assertion helpers shared by the trimmed-mean core.
`ifndef TRIMMED_MEAN_THREE_CHANNEL_CORE_DEFINES_SVH
`define TRIMMED_MEAN_THREE_CHANNEL_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define TMT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define TMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/tmt_pkg.sv -----
package tmt_pkg;

   localparam int MAX_SAMPLES = 32;
   localparam int SAMPLE_BITS = 16;

   localparam int ADDR_W  = $clog2(MAX_SAMPLES);
   localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W   = SAMPLE_BITS + ADDR_W;
   localparam int STEP_W  = $clog2(SUM_W + 1);
   localparam int WORD_W  = 3 * SAMPLE_BITS;

   // Register field widths, fixed by the register map.
   localparam int SC_W    = 6;
   localparam int WARM_W  = 8;
   localparam int DROP_W  = 5;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_WARMUP_COUNT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_DROP_LOW     = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_DROP_HIGH    = 2'd3;

   localparam logic [SC_W-1:0]   SAMPLE_COUNT_RESET = 6'd10;
   localparam logic [WARM_W-1:0] WARMUP_COUNT_RESET = 8'd5;
   localparam logic [DROP_W-1:0] DROP_LOW_RESET     = 5'd1;
   localparam logic [DROP_W-1:0] DROP_HIGH_RESET    = 5'd1;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SUM_W-1:0]       sum_type;

endpackage

// ----- design/tmt_if.sv -----
interface tmt_req_if;
   logic                  valid;
   logic                  ready;
   tmt_pkg::sample_type   pm1_sample;
   tmt_pkg::sample_type   pm25_sample;
   tmt_pkg::sample_type   pm10_sample;

   modport source (output valid, pm1_sample, pm25_sample, pm10_sample, input ready);
   modport sink (input valid, pm1_sample, pm25_sample, pm10_sample, output ready);
endinterface

interface tmt_rsp_if;
   logic                  valid;
   logic                  ready;
   tmt_pkg::sample_type   pm1_mean;
   tmt_pkg::sample_type   pm25_mean;
   tmt_pkg::sample_type   pm10_mean;
   logic                  nothing_kept;

   modport source (output valid, pm1_mean, pm25_mean, pm10_mean, nothing_kept,
                   input ready);
   modport sink (input valid, pm1_mean, pm25_mean, pm10_mean, nothing_kept,
                 output ready);
endinterface

// ----- design/tmt_ram.sv -----
module tmt_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/tmt_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tmt_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  tmt_pkg::sum_type            dividend,
   input  logic [tmt_pkg::CNT_W-1:0]   divisor,
   output tmt_pkg::sample_type         quotient,
   output logic                        done
);

   tmt_pkg::sum_type                 quo_ff, quo_in;
   logic [tmt_pkg::CNT_W-1:0]        rem_ff, rem_in;
   logic [tmt_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [tmt_pkg::CNT_W:0]          trial;
   logic [tmt_pkg::CNT_W:0]          diff;
   logic                             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[tmt_pkg::SUM_W-1]};
      diff    = trial - {1'b0, divisor};
      fits    = (trial >= {1'b0, divisor});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[tmt_pkg::SUM_W-2:0], fits};
         rem_in  = fits ? diff[tmt_pkg::CNT_W-1:0] : trial[tmt_pkg::CNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == tmt_pkg::STEP_W'(tmt_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff[tmt_pkg::SAMPLE_BITS-1:0];
   assign done     = done_ff;

endmodule

// ----- design/trimmed_mean_three_channel_core.sv -----
// Trimmed-mean core for three-channel particle readings.
// Requests arrive on req_chan (valid/ready), each one reading of PM1.0, PM2.5
// and PM10. After warmup_count readings are dropped, sample_count readings
// are written into one 48-bit wide, 32-entry RAM. The request that fills the
// window closes it; no other request produces a response.
// At close the block ranks each stored reading against all others by reading
// the RAM once per entry, one entry per cycle. Readings whose rank falls
// inside the kept band are summed per channel; after a start state three
// serial dividers produce the means. When the drops leave nothing, ranking
// and division are skipped and the response carries zero means with
// nothing_kept set.
// Requests that do not close a window are taken one per cycle; while a window
// is being reduced req_chan.ready is low.
// The response sits in an output register; the next window can be loaded
// while it waits, and a new result is held back until the previous one has
// been taken on rsp_chan.
// Synchronous reset restores the register defaults and restarts warmup; the
// RAM is not cleared, since only entries of the current window are read.
module trimmed_mean_three_channel_core (
   input  logic                                clock,
   input  logic                                reset,
   tmt_req_if.sink                             req_chan,
   tmt_rsp_if.source                           rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tmt_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [tmt_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [tmt_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

`include "trimmed_mean_three_channel_core_defines.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PIVOT_RD,
      ST_PIVOT_LD,
      ST_SCAN,
      ST_ACCUM,
      ST_DIV_START,
      ST_DIV,
      ST_RESULT
   } state_type;

   localparam int SB = tmt_pkg::SAMPLE_BITS;

   // Configuration registers.
   logic [tmt_pkg::SC_W-1:0]   sample_count_ff, sample_count_in;
   logic [tmt_pkg::WARM_W-1:0] warmup_count_ff, warmup_count_in;
   logic [tmt_pkg::DROP_W-1:0] drop_low_ff, drop_low_in;
   logic [tmt_pkg::DROP_W-1:0] drop_high_ff, drop_high_in;

   // Window bookkeeping.
   logic [tmt_pkg::WARM_W-1:0] warmup_seen_ff, warmup_seen_in;
   logic [tmt_pkg::CNT_W-1:0]  stored_count_ff, stored_count_in;
   logic                       in_warmup_ff, in_warmup_in;

   // Reduction sequencer.
   state_type                  state_ff, state_in;
   logic [tmt_pkg::CNT_W-1:0]  m_ff, m_in;
   logic [tmt_pkg::CNT_W-1:0]  hi_ff, hi_in;
   logic [tmt_pkg::CNT_W-1:0]  kept_ff, kept_in;
   logic                       nothing_ff, nothing_in;
   logic [tmt_pkg::CNT_W-1:0]  i_ff, i_in;
   logic [tmt_pkg::CNT_W-1:0]  j_ff, j_in;
   logic                       cmp_valid_ff, cmp_valid_in;
   logic [tmt_pkg::ADDR_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [tmt_pkg::WORD_W-1:0] pivot_ff, pivot_in;
   logic [tmt_pkg::ADDR_W-1:0] rank_ff [3];
   logic [tmt_pkg::ADDR_W-1:0] rank_in [3];
   tmt_pkg::sum_type           sum_ff [3];
   tmt_pkg::sum_type           sum_in [3];

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   tmt_pkg::sample_type        mean_ff [3];
   tmt_pkg::sample_type        mean_in [3];
   logic                       rsp_nothing_ff, rsp_nothing_in;

   // RAM and divider hookup.
   logic                       ram_wr_en;
   logic [tmt_pkg::WORD_W-1:0] ram_wr_data;
   logic                       ram_rd_en;
   logic [tmt_pkg::ADDR_W-1:0] ram_rd_addr;
   logic [tmt_pkg::WORD_W-1:0] ram_rd_data;
   logic                       div_start;
   tmt_pkg::sample_type        quot [3];
   logic [2:0]                 div_done;

   // Request side.
   logic                       req_fire;
   logic                       warm_skip;
   logic                       store_now;
   logic                       close_now;
   logic [tmt_pkg::CNT_W-1:0]  count_inc;
   logic [tmt_pkg::CNT_W-1:0]  n_eff;
   logic [tmt_pkg::DROP_W:0]   drop_sum;
   logic                       drops_all;
   logic                       cfg_write;
   logic [tmt_pkg::REG_IDX_W-1:0] cfg_idx;
   logic                       rsp_free;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign warm_skip = in_warmup_ff && (warmup_seen_ff < warmup_count_ff);
   assign store_now = req_fire && !warm_skip;
   assign count_inc = stored_count_ff + 1'b1;
   assign drop_sum  = {1'b0, drop_low_ff} + {1'b0, drop_high_ff};
   assign drops_all = (int'(drop_sum) >= int'(count_inc));
   assign close_now = store_now && (count_inc >= n_eff);
   assign cfg_write = psel && penable && pwrite;
   assign cfg_idx   = paddr[tmt_pkg::CSR_ADDR_W-1:2];
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   // A window size of zero counts as one; sizes past capacity saturate.
   always_comb begin
      if (sample_count_ff == '0) begin
         n_eff = tmt_pkg::CNT_W'(1);
      end else if (int'(sample_count_ff) > tmt_pkg::MAX_SAMPLES) begin
         n_eff = tmt_pkg::CNT_W'(tmt_pkg::MAX_SAMPLES);
      end else begin
         n_eff = tmt_pkg::CNT_W'(sample_count_ff);
      end
   end

   // Register readback.
   always_comb begin
      unique case (cfg_idx)
         tmt_pkg::REG_SAMPLE_COUNT: prdata = tmt_pkg::CSR_DATA_W'(sample_count_ff);
         tmt_pkg::REG_WARMUP_COUNT: prdata = tmt_pkg::CSR_DATA_W'(warmup_count_ff);
         tmt_pkg::REG_DROP_LOW:     prdata = tmt_pkg::CSR_DATA_W'(drop_low_ff);
         tmt_pkg::REG_DROP_HIGH:    prdata = tmt_pkg::CSR_DATA_W'(drop_high_ff);
         default:                   prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // The RAM holds one reading per entry, channels packed as PM10, PM2.5, PM1.0.
   assign ram_wr_en   = store_now;
   assign ram_wr_data = {req_chan.pm10_sample, req_chan.pm25_sample, req_chan.pm1_sample};
   assign ram_rd_en   = (state_ff == ST_PIVOT_RD) || (state_ff == ST_SCAN);
   assign ram_rd_addr = (state_ff == ST_PIVOT_RD) ? i_ff[tmt_pkg::ADDR_W-1:0]
                                                  : j_ff[tmt_pkg::ADDR_W-1:0];
   assign div_start   = (state_ff == ST_DIV_START);

   tmt_ram #(
      .WIDTH (tmt_pkg::WORD_W),
      .DEPTH (tmt_pkg::MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (stored_count_ff[tmt_pkg::ADDR_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   for (genvar c = 0; c < 3; c++) begin : g_div
      tmt_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (sum_ff[c]),
         .divisor  (kept_ff),
         .quotient (quot[c]),
         .done     (div_done[c])
      );
   end

   // Next-state logic for everything clocked below.
   always_comb begin
      logic [SB-1:0] data_c;
      logic [SB-1:0] piv_c;
      logic          less;
      logic          keep;

      data_c          = '0;
      piv_c           = '0;
      less            = 1'b0;
      keep            = 1'b0;
      sample_count_in = sample_count_ff;
      warmup_count_in = warmup_count_ff;
      drop_low_in     = drop_low_ff;
      drop_high_in    = drop_high_ff;
      warmup_seen_in  = warmup_seen_ff;
      stored_count_in = stored_count_ff;
      in_warmup_in    = in_warmup_ff;
      state_in        = state_ff;
      m_in            = m_ff;
      hi_in           = hi_ff;
      kept_in         = kept_ff;
      nothing_in      = nothing_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      cmp_valid_in    = 1'b0;
      cmp_idx_in      = cmp_idx_ff;
      pivot_in        = pivot_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_nothing_in  = rsp_nothing_ff;
      for (int c = 0; c < 3; c++) begin
         rank_in[c] = rank_ff[c];
         sum_in[c]  = sum_ff[c];
         mean_in[c] = mean_ff[c];
      end

      if (cfg_write) begin
         unique case (cfg_idx)
            tmt_pkg::REG_SAMPLE_COUNT: sample_count_in = pwdata[tmt_pkg::SC_W-1:0];
            tmt_pkg::REG_WARMUP_COUNT: warmup_count_in = pwdata[tmt_pkg::WARM_W-1:0];
            tmt_pkg::REG_DROP_LOW:     drop_low_in     = pwdata[tmt_pkg::DROP_W-1:0];
            tmt_pkg::REG_DROP_HIGH:    drop_high_in    = pwdata[tmt_pkg::DROP_W-1:0];
            default: ;
         endcase
      end

      // Warmup counting and window filling.
      if (req_fire) begin
         if (warm_skip) begin
            warmup_seen_in = warmup_seen_ff + 1'b1;
         end else begin
            in_warmup_in    = 1'b0;
            stored_count_in = count_inc;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (close_now) begin
               stored_count_in = '0;
               warmup_seen_in  = '0;
               in_warmup_in    = 1'b1;
               m_in            = count_inc;
               hi_in           = count_inc - tmt_pkg::CNT_W'(drop_high_ff);
               kept_in         = count_inc - tmt_pkg::CNT_W'(drop_low_ff)
                                 - tmt_pkg::CNT_W'(drop_high_ff);
               nothing_in      = drops_all;
               i_in            = '0;
               for (int c = 0; c < 3; c++) begin
                  rank_in[c] = '0;
                  sum_in[c]  = '0;
               end
               state_in = drops_all ? ST_RESULT : ST_PIVOT_RD;
            end
         end
         ST_PIVOT_RD: begin
            state_in = ST_PIVOT_LD;
         end
         ST_PIVOT_LD: begin
            pivot_in = ram_rd_data;
            j_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Issue one read per cycle; compare the entry read the cycle before.
            if (j_ff != m_ff) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = j_ff[tmt_pkg::ADDR_W-1:0];
               j_in         = j_ff + 1'b1;
            end else if (!cmp_valid_ff) begin
               state_in = ST_ACCUM;
            end
            if (cmp_valid_ff) begin
               for (int c = 0; c < 3; c++) begin
                  data_c = ram_rd_data[c*SB +: SB];
                  piv_c  = pivot_ff[c*SB +: SB];
                  // Ties are broken by position, which gives each reading
                  // exactly its place in a stable ascending sort.
                  less = (data_c < piv_c) ||
                         ((data_c == piv_c) && (cmp_idx_ff < i_ff[tmt_pkg::ADDR_W-1:0]));
                  if (less) begin
                     rank_in[c] = rank_ff[c] + 1'b1;
                  end
               end
            end
         end
         ST_ACCUM: begin
            for (int c = 0; c < 3; c++) begin
               keep = (rank_ff[c] >= drop_low_ff) &&
                      (tmt_pkg::CNT_W'(rank_ff[c]) < hi_ff);
               if (keep) begin
                  sum_in[c] = sum_ff[c] + tmt_pkg::SUM_W'(pivot_ff[c*SB +: SB]);
               end
               rank_in[c] = '0;
            end
            if (i_ff + 1'b1 == m_ff) begin
               state_in = ST_DIV_START;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_PIVOT_RD;
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (&div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_nothing_in = nothing_ff;
               for (int c = 0; c < 3; c++) begin
                  mean_in[c] = nothing_ff ? '0 : quot[c];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff           <= m_in;
      hi_ff          <= hi_in;
      kept_ff        <= kept_in;
      nothing_ff     <= nothing_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      cmp_idx_ff     <= cmp_idx_in;
      pivot_ff       <= pivot_in;
      rsp_nothing_ff <= rsp_nothing_in;
      for (int c = 0; c < 3; c++) begin
         rank_ff[c] <= rank_in[c];
         sum_ff[c]  <= sum_in[c];
         mean_ff[c] <= mean_in[c];
      end
      if (reset) begin
         sample_count_ff <= tmt_pkg::SAMPLE_COUNT_RESET;
         warmup_count_ff <= tmt_pkg::WARMUP_COUNT_RESET;
         drop_low_ff     <= tmt_pkg::DROP_LOW_RESET;
         drop_high_ff    <= tmt_pkg::DROP_HIGH_RESET;
         warmup_seen_ff  <= '0;
         stored_count_ff <= '0;
         in_warmup_ff    <= 1'b1;
         state_ff        <= ST_IDLE;
         cmp_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sample_count_ff <= sample_count_in;
         warmup_count_ff <= warmup_count_in;
         drop_low_ff     <= drop_low_in;
         drop_high_ff    <= drop_high_in;
         warmup_seen_ff  <= warmup_seen_in;
         stored_count_ff <= stored_count_in;
         in_warmup_ff    <= in_warmup_in;
         state_ff        <= state_in;
         cmp_valid_ff    <= cmp_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pm1_mean     = mean_ff[0];
   assign rsp_chan.pm25_mean    = mean_ff[1];
   assign rsp_chan.pm10_mean    = mean_ff[2];
   assign rsp_chan.nothing_kept = rsp_nothing_ff;

   // An empty band must come out as all-zero means.
   `TMT_ASSERT_IMPLY(a_nothing_zero, clock, reset,
      rsp_chan.valid && rsp_chan.nothing_kept,
      (rsp_chan.pm1_mean == '0) && (rsp_chan.pm25_mean == '0) && (rsp_chan.pm10_mean == '0),
      "nothing_kept response carries a nonzero mean")

   // The write pointer never runs past the RAM.
   `TMT_ASSERT_IMPLY(a_count_bound, clock, reset,
      1'b1, int'(stored_count_ff) < tmt_pkg::MAX_SAMPLES,
      "stored count reached RAM capacity")

   // A closing request always leaves idle and blocks new requests.
   `TMT_ASSERT_NEXT(a_close_busy, clock, reset,
      req_fire && close_now, !req_chan.ready,
      "window closed without leaving idle")

endmodule

// ----- tb/testbench.sv -----
// Testbench for the three-channel trimmed-mean core.
//
// Readings are sent on the request channel and the configuration is set
// through the APB-style port. A predictor inside this module tracks warmup,
// window fill and the four registers, and computes the expected means for
// each window when it closes. Every response is compared with the oldest
// prediction.
module testbench;
   import tmt_pkg::*;

   // The slowest window to reduce holds 32 readings. The limit is far above
   // anything a correct run can need.
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int SETTLE_CYCLES   = 16;
   localparam int RANDOM_READINGS = 1750;
   localparam int REPORT_LIMIT    = 10;
   localparam int MAX_IDLE        = 4;

   typedef sample_type reading_set_type [MAX_SAMPLES];

   typedef struct packed {
      sample_type pm1;
      sample_type pm25;
      sample_type pm10;
      logic       nothing_kept;
   } mean_set_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tmt_req_if req_chan ();
   tmt_rsp_if rsp_chan ();

   trimmed_mean_three_channel_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Predictor state. The window stores mirror the block's RAM, and the
   // counters follow the warmup and fill of the window in progress.
   reading_set_type pm1_window;
   reading_set_type pm25_window;
   reading_set_type pm10_window;
   int unsigned  warmup_seen_count;
   int unsigned  window_fill;
   bit           warming_up;

   // Register values as the predictor knows them.
   int unsigned  cur_sample_count;
   int unsigned  cur_warmup_count;
   int unsigned  cur_drop_low;
   int unsigned  cur_drop_high;

   // Means of closed windows whose response has not come back yet.
   mean_set_type expected_means[$];

   int unsigned  sent_readings;
   int unsigned  error_count;
   int unsigned  cycle_count;

   // Longest pause that each side may draw before its next request.
   int unsigned  req_gap_max;
   int unsigned  rsp_stall_max;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: the run may never outlast the cycle limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic note_failure(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("ERROR: %s", what);
      end
   endtask

   // Sorts one channel's window ascending and averages the kept band, which
   // starts right after the lo lowest values and holds kept values. The sum
   // is 64 bits wide, so it never wraps.
   function automatic sample_type trimmed_average(input reading_set_type vals,
                                                 input int unsigned m,
                                                 input int unsigned lo,
                                                 input int unsigned kept);
      sample_type      x;
      longint unsigned total;
      int              j;
      for (int i = 1; i < m; i++) begin
         x = vals[i];
         j = i;
         while (j > 0 && vals[j-1] > x) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = x;
      end
      total = 0;
      for (int unsigned i = lo; i < lo + kept; i++) begin
         total += vals[i];
      end
      return sample_type'(total / kept);
   endfunction

   // Window size in effect: zero counts as one, and anything above the RAM
   // depth is clipped to the depth.
   function automatic int unsigned effective_size(input int unsigned sc);
      if (sc == 0) begin
         return 1;
      end
      if (sc > MAX_SAMPLES) begin
         return MAX_SAMPLES;
      end
      return sc;
   endfunction

   // Advances the predictor by one accepted reading. A reading either counts
   // toward warmup, or is stored; the one that fills the window closes it and
   // queues the expected means.
   function automatic void absorb_reading(input sample_type a,
                                          input sample_type b,
                                          input sample_type c);
      int unsigned  m;
      int unsigned  kept;
      mean_set_type r;
      if (warming_up) begin
         if (warmup_seen_count < cur_warmup_count) begin
            warmup_seen_count = (warmup_seen_count + 1) % 256;
            return;
         end
         // The warmup ends here, also when warmup_count was lowered below
         // the count already seen.
         warming_up = 1'b0;
      end
      if (window_fill >= MAX_SAMPLES) begin
         window_fill = MAX_SAMPLES - 1;
      end
      pm1_window[window_fill]  = a;
      pm25_window[window_fill] = b;
      pm10_window[window_fill] = c;
      window_fill++;
      // A window size lowered to or below the fill closes the window now.
      if (window_fill < effective_size(cur_sample_count)) begin
         return;
      end
      m = window_fill;
      window_fill = 0;
      warmup_seen_count = 0;
      warming_up = 1'b1;
      if (cur_drop_low + cur_drop_high >= m) begin
         r.pm1 = '0;
         r.pm25 = '0;
         r.pm10 = '0;
         r.nothing_kept = 1'b1;
      end else begin
         kept = m - cur_drop_low - cur_drop_high;
         r.pm1 = trimmed_average(pm1_window, m, cur_drop_low, kept);
         r.pm25 = trimmed_average(pm25_window, m, cur_drop_low, kept);
         r.pm10 = trimmed_average(pm10_window, m, cur_drop_low, kept);
         r.nothing_kept = 1'b0;
      end
      expected_means.push_back(r);
   endfunction

   // Sends one reading as a request. The pause before it is drawn at random,
   // and valid stays high straight into the next request when no pause is
   // drawn. The predictor sees the reading at the edge that accepts it.
   task automatic send_reading(input sample_type a, input sample_type b,
                               input sample_type c);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.pm1_sample  <= a;
      req_chan.pm25_sample <= b;
      req_chan.pm10_sample <= c;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      absorb_reading(a, b, c);
      sent_readings++;
   endtask

   // Stops sending and waits for every expected response. The extra cycles
   // cover requests that closed no window and may still be settling.
   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB write: a setup phase, then an access phase that completes at
   // the edge where pready is high, then an idle phase. Only called while
   // the block is idle.
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_SAMPLE_COUNT: cur_sample_count = value % (1 << SC_W);
         REG_WARMUP_COUNT: cur_warmup_count = value % (1 << WARM_W);
         REG_DROP_LOW:     cur_drop_low     = value % (1 << DROP_W);
         REG_DROP_HIGH:    cur_drop_high    = value % (1 << DROP_W);
         default: ;
      endcase
   endtask

   // Mostly full-range values, with a good share of the extremes and of
   // small values so that ties and near-ties show up in the sort.
   function automatic sample_type random_reading();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return sample_type'($urandom_range(0, 15));
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Response side: draws a stall before each response, then holds ready
   // high until a response is taken, and checks it against the oldest
   // prediction.
   initial begin
      int unsigned  stall;
      mean_set_type got;
      mean_set_type want;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         got.pm1 = rsp_chan.pm1_mean;
         got.pm25 = rsp_chan.pm25_mean;
         got.pm10 = rsp_chan.pm10_mean;
         got.nothing_kept = rsp_chan.nothing_kept;
         if (expected_means.size() == 0) begin
            note_failure($sformatf("response with no window closed: %0d %0d %0d kept0=%0b",
                                   got.pm1, got.pm25, got.pm10, got.nothing_kept));
         end else begin
            want = expected_means.pop_front();
            if (got.pm1 !== want.pm1 || got.pm25 !== want.pm25 ||
                got.pm10 !== want.pm10 || got.nothing_kept !== want.nothing_kept) begin
               note_failure($sformatf(
                  "means expected %0d %0d %0d kept0=%0b, got %0d %0d %0d kept0=%0b",
                  want.pm1, want.pm25, want.pm10, want.nothing_kept,
                  got.pm1, got.pm25, got.pm10, got.nothing_kept));
            end
         end
      end
   end

   // Reset values: warmup of 5, window of 10, one value dropped at each end.
   // After the warmup and three stored readings the window size is lowered
   // to three, so the next reading closes a window of four.
   task automatic test_defaults_and_early_close();
      repeat (5) send_reading(random_reading(), random_reading(), random_reading());
      send_reading(16'd0, 16'hFFFF, 16'd4660);
      send_reading(16'hFFFF, 16'd0, 16'h8000);
      send_reading(16'h7FFF, 16'h8001, 16'd0);
      wait_until_drained();
      csr_write(REG_SAMPLE_COUNT, 3);
      send_reading(16'd1, 16'hFFFE, 16'hFFFF);
      wait_until_drained();
   endtask

   // A long warmup is cut short once three readings have been discarded:
   // the next reading ends the warmup and fills a one-reading window.
   task automatic test_warmup_cut_short();
      csr_write(REG_WARMUP_COUNT, 255);
      csr_write(REG_SAMPLE_COUNT, 1);
      csr_write(REG_DROP_LOW, 0);
      csr_write(REG_DROP_HIGH, 0);
      repeat (3) send_reading(random_reading(), random_reading(), random_reading());
      wait_until_drained();
      csr_write(REG_WARMUP_COUNT, 2);
      send_reading(16'hFFFF, 16'd0, 16'hFFFF);
      wait_until_drained();
   endtask

   // A window size of zero behaves as one: every reading is its own mean.
   task automatic test_zero_window_size();
      csr_write(REG_SAMPLE_COUNT, 0);
      csr_write(REG_WARMUP_COUNT, 0);
      send_reading(16'd0, 16'd0, 16'd0);
      send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF);
      wait_until_drained();
   endtask

   // Drops that use up the whole window give zeros with the flag set; one
   // fewer drop keeps a single value per channel.
   task automatic test_nothing_kept();
      csr_write(REG_SAMPLE_COUNT, 2);
      csr_write(REG_DROP_LOW, 1);
      csr_write(REG_DROP_HIGH, 1);
      send_reading(16'hFFFF, 16'd5, 16'd0);
      send_reading(16'd0, 16'd6, 16'hFFFF);
      wait_until_drained();
      csr_write(REG_DROP_LOW, 0);
      send_reading(16'hFFFF, 16'd5, 16'd0);
      send_reading(16'd0, 16'd6, 16'hFFFF);
      wait_until_drained();
   endtask

   // Random phases. Each phase drains the block, writes all four registers
   // and sends whole windows plus a partial one, so the next phase often
   // changes the settings in the middle of a window or a warmup. Most
   // windows are small; a few take the full depth or sizes above it.
   task automatic test_random_windows();
      int unsigned start_count;
      int unsigned sc;
      int unsigned warm;
      int unsigned size;
      int unsigned readings;
      start_count = sent_readings;
      while (sent_readings - start_count < RANDOM_READINGS) begin
         wait_until_drained();
         case ($urandom_range(0, 19))
            0:       sc = 0;
            1:       sc = MAX_SAMPLES;
            2:       sc = $urandom_range(MAX_SAMPLES + 1, (1 << SC_W) - 1);
            3, 4, 5: sc = $urandom_range(9, MAX_SAMPLES - 1);
            default: sc = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 19))
            0:             warm = (1 << WARM_W) - 1;
            1, 2:          warm = $urandom_range(4, 40);
            3, 4, 5, 6, 7: warm = 0;
            default:       warm = $urandom_range(1, 3);
         endcase
         csr_write(REG_SAMPLE_COUNT, sc);
         csr_write(REG_WARMUP_COUNT, warm);
         csr_write(REG_DROP_LOW,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << DROP_W) - 1)
                                               : $urandom_range(0, 3));
         csr_write(REG_DROP_HIGH,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << DROP_W) - 1)
                                               : $urandom_range(0, 3));
         // Some phases run with no pauses at all on one side or both.
         req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_IDLE;
         rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_IDLE;
         size = effective_size(sc);
         readings = (warm + size) * ((warm > 40) ? 1 : $urandom_range(1, 3))
                    + $urandom_range(0, size);
         repeat (readings) send_reading(random_reading(), random_reading(),
                                        random_reading());
      end
   endtask

   initial begin
      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.pm1_sample  <= '0;
      req_chan.pm25_sample <= '0;
      req_chan.pm10_sample <= '0;
      req_gap_max       = MAX_IDLE;
      rsp_stall_max     = MAX_IDLE;
      error_count       = 0;
      sent_readings     = 0;
      warmup_seen_count = 0;
      window_fill       = 0;
      warming_up        = 1'b1;
      cur_sample_count  = SAMPLE_COUNT_RESET;
      cur_warmup_count  = WARMUP_COUNT_RESET;
      cur_drop_low      = DROP_LOW_RESET;
      cur_drop_high     = DROP_HIGH_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults_and_early_close();
      test_warmup_cut_short();
      test_zero_window_size();
      test_nothing_kept();
      test_random_windows();

      wait_until_drained();
      if (expected_means.size() != 0) begin
         note_failure($sformatf("%0d expected responses never came",
                                expected_means.size()));
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
